// ===== rtl/spike_gated_iir_filter_macros.svh =====
// Assertion helpers shared by the filter RTL.
`ifndef SPIKE_GATED_IIR_FILTER_MACROS_SVH
`define SPIKE_GATED_IIR_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset.
`define SGIIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SGIIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SGIIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define SGIIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/sgiir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sgiir_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 24;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 48;
    localparam int SUM_W       = ACC_W + 2;
    localparam int ROUND_SHIFT = 20;
    localparam int OUT_WIDE_W  = SUM_W - ROUND_SHIFT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int REG_FEED_0      = 0;
    localparam int REG_FEEDBACK_1  = 4;
    localparam int REG_SPIKE_LIMIT = 7;
    localparam int NUM_FEED_REGS   = 4;
    localparam int NUM_FBK_REGS    = 3;

    localparam logic signed [COEF_W-1:0]   FEED0_RESET = 24'sd1048576;
    localparam logic signed [SAMPLE_W-1:0] SPIKE_RESET = 24'sd128000;
    localparam logic signed [SUM_W-1:0]    ROUND_HALF  = SUM_W'(1) << (ROUND_SHIFT - 1);

    typedef enum logic [1:0] {
        MUL_HOLD,
        MUL_B0,
        MUL_FEED,
        MUL_FBK
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_Z0,
        ACC_LOAD_NEXT,
        ACC_ADD_SAT,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     take;
        mul_sel_t mul;
        acc_op_t  acc;
        logic     rnd;
        logic     z_wr;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Clamp a widened sum to the accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[SUM_W-1:ACC_W-1];
        hi_zeros = ~|v[SUM_W-1:ACC_W-1];
        if (hi_ones || hi_zeros)
        begin
            return v[ACC_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

    // Clamp the shifted result to the sample range; top bit flags clipping.
    function automatic logic [SAMPLE_W:0] sat_out(input logic signed [OUT_WIDE_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[OUT_WIDE_W-1:SAMPLE_W-1];
        hi_zeros = ~|v[OUT_WIDE_W-1:SAMPLE_W-1];
        if (hi_ones || hi_zeros)
        begin
            return {1'b0, v[SAMPLE_W-1:0]};
        end
        else if (v[OUT_WIDE_W-1])
        begin
            return {1'b1, 1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            return {1'b1, 1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sgiir_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sgiir_in_if
    import sgiir_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       mode;

    modport source (output valid, output sample, output mode, input ready);
    modport sink (input valid, input sample, input mode, output ready);
endinterface

interface sgiir_out_if
    import sgiir_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       replaced;
    logic                       clipped;

    modport source (output valid, output filtered, output replaced, output clipped, input ready);
    modport sink (input valid, input filtered, input replaced, input clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/spike_gated_iir_filter.sv =====
// Per request: the single shared multiplier forms b0*x, then two products (feed and
// feedback) per delay term, and the result is then loaded into the output register.
// No new request is taken until the current result has been loaded there.
// A finished result waits in an output register; the next request is taken meanwhile.
// Reset: b0 = 1.0, other coefficients 0, spike limit 500.0, delay line and previous
// sample cleared at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module spike_gated_iir_filter
    import sgiir_pkg::*;
#(
    parameter int TAPS = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sgiir_in_if.sink                   samples,
    sgiir_out_if.source                results,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(TAPS);

    // Controller to datapath: one command word per cycle, plus the term counter.
    dp_cmd_t       cmd;
    dp_status_t    status;
    logic [CW-1:0] k;

    // Sequencer: take a request, run b0*x, round the output, then walk the
    // delay terms from the front, two products each, and hand off the result.
    sgiir_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd),
        .k        (k)
    );

    // Datapath: spike gate, coefficient registers, shared multiplier,
    // wide accumulator with saturation, delay terms and the output register.
    sgiir_datapath #(
        .TAPS (TAPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .k         (k),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (samples.sample),
        .mode      (samples.mode),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .filtered  (results.filtered),
        .replaced  (results.replaced),
        .clipped   (results.clipped)
    );

endmodule

`default_nettype wire

// ===== rtl/sgiir_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "spike_gated_iir_filter_macros.svh"

module sgiir_ctrl
    import sgiir_pkg::*;
#(
    parameter int TAPS = 4,
    localparam int CW = $clog2(TAPS)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dp_status_t    status,
    output dp_cmd_t            cmd,
    output logic [CW-1:0]      k
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B0,
        ST_ACC0,
        ST_FEED,
        ST_FBK,
        ST_FIN
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] k_reg, k_next;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul      = MUL_HOLD;
        cmd.acc      = ACC_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid)
                begin
                    state_next = ST_B0;
                end
            end
            ST_B0:
            begin
                cmd.mul    = MUL_B0;
                cmd.acc    = ACC_LOAD_Z0;
                state_next = ST_ACC0;
            end
            ST_ACC0:
            begin
                cmd.acc    = ACC_ADD_SAT;
                k_next     = '0;
                state_next = ST_FEED;
            end
            ST_FEED:
            begin
                // first pass also rounds the output; later passes retire term k-1
                cmd.mul    = MUL_FEED;
                cmd.acc    = ACC_LOAD_NEXT;
                cmd.rnd    = (k_reg == '0);
                cmd.z_wr   = (k_reg != '0);
                state_next = ST_FBK;
            end
            ST_FBK:
            begin
                cmd.mul = MUL_FBK;
                cmd.acc = ACC_ADD;
                k_next  = k_reg + CW'(1);
                if (k_reg == CW'(TAPS - 2))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FIN:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.z_wr     = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign k = k_reg;

    `SGIIR_ASSERT_IMP(a_result_after_last_term, clk, rst_n, cmd.out_load, k_reg == CW'(TAPS - 1), "result issued before all delay terms")
    `SGIIR_ASSERT_NXT(a_one_item_in_flight, clk, rst_n, cmd.take, !in_ready, "second request taken while busy")

endmodule

`default_nettype wire

// ===== rtl/sgiir_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "spike_gated_iir_filter_macros.svh"

module sgiir_datapath
    import sgiir_pkg::*;
#(
    parameter int TAPS = 4,
    localparam int CW = $clog2(TAPS),
    localparam int ZW = (TAPS > 2) ? $clog2(TAPS - 1) : 1
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_cmd_t                    cmd,
    input  wire logic [CW-1:0]              k,
    output dp_status_t                      status,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       mode,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      filtered,
    output logic                            replaced,
    output logic                            clipped
);

    logic signed [COEF_W-1:0]   feed_reg [TAPS];
    logic signed [COEF_W-1:0]   fbk_reg  [1:TAPS-1];
    logic signed [SAMPLE_W-1:0] spike_reg;
    logic signed [ACC_W-1:0]    z_reg    [TAPS-1];
    logic signed [SAMPLE_W-1:0] prev_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       rep_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       clip_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                       replaced_reg;
    logic                       clipped_reg;

    logic [CW-1:0]              nxt;
    logic [CW-1:0]              k_prev;
    logic [ZW-1:0]              rd_idx;
    logic [ZW-1:0]              wr_idx;
    logic                       has_next;
    logic signed [COEF_W-1:0]   mult_a;
    logic signed [SAMPLE_W-1:0] mult_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SUM_W-1:0]    sum_add;
    logic signed [SUM_W-1:0]    sum_sub;
    logic signed [SUM_W-1:0]    rounded;
    logic [SAMPLE_W:0]          y_sat;
    logic                       is_spike;

    assign nxt      = k + CW'(1);
    assign k_prev   = k - CW'(1);
    assign rd_idx   = nxt[ZW-1:0];
    assign wr_idx   = k_prev[ZW-1:0];
    assign has_next = (int'(nxt) < TAPS - 1);
    assign is_spike = !mode && (sample > spike_reg);

    // Coefficient and limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                feed_reg[i] <= (i == 0) ? FEED0_RESET : '0;
            end
            for (int i = 1; i < TAPS; i++)
            begin
                fbk_reg[i] <= '0;
            end
            spike_reg <= SPIKE_RESET;
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                if (i < NUM_FEED_REGS && cfg_index == CFG_IDX_W'(REG_FEED_0 + i))
                begin
                    feed_reg[i] <= cfg_data;
                end
            end
            for (int i = 1; i < TAPS; i++)
            begin
                if (i <= NUM_FBK_REGS && cfg_index == CFG_IDX_W'(REG_FEEDBACK_1 + i - 1))
                begin
                    fbk_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == CFG_IDX_W'(REG_SPIKE_LIMIT))
            begin
                spike_reg <= cfg_data;
            end
        end
    end

    // Spike gate: swap in the previous raw sample, track raw checked samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (cmd.take && !mode)
        begin
            prev_reg <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            x_reg   <= is_spike ? prev_reg : sample;
            rep_reg <= is_spike;
        end
    end

    // Shared multiplier.
    always_comb
    begin
        case (cmd.mul)
            MUL_B0:
            begin
                mult_a = feed_reg[0];
                mult_b = x_reg;
            end
            MUL_FEED:
            begin
                mult_a = feed_reg[nxt];
                mult_b = x_reg;
            end
            MUL_FBK:
            begin
                mult_a = fbk_reg[nxt];
                mult_b = y_reg;
            end
            default:
            begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign prod_next = mult_a * mult_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul != MUL_HOLD)
        begin
            prod_reg <= prod_next;
        end
    end

    // Accumulator.
    assign sum_add = acc_reg + SUM_W'(prod_reg);
    assign sum_sub = acc_reg - SUM_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        case (cmd.acc)
            ACC_LOAD_Z0:   acc_reg <= SUM_W'(z_reg[0]);
            ACC_LOAD_NEXT: acc_reg <= has_next ? SUM_W'(z_reg[rd_idx]) : '0;
            ACC_ADD_SAT:   acc_reg <= SUM_W'(sat_acc(sum_add));
            ACC_ADD:       acc_reg <= sum_add;
            default:       acc_reg <= acc_reg;
        endcase
    end

    // Round half up, then clamp to the sample range.
    assign rounded = acc_reg + ROUND_HALF;
    assign y_sat   = sat_out(rounded[SUM_W-1:ROUND_SHIFT]);

    always_ff @(posedge clk)
    begin
        if (cmd.rnd)
        begin
            y_reg    <= y_sat[SAMPLE_W-1:0];
            clip_reg <= y_sat[SAMPLE_W];
        end
    end

    // Delay terms.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                z_reg[i] <= '0;
            end
        end
        else if (cmd.z_wr)
        begin
            z_reg[wr_idx] <= sat_acc(sum_sub);
        end
    end

    // Output register.
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            filtered_reg <= y_reg;
            replaced_reg <= rep_reg;
            clipped_reg  <= clip_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign replaced  = replaced_reg;
    assign clipped   = clipped_reg;

    `SGIIR_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready, "result overwritten before taken")
    `SGIIR_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid_reg, "loaded result not presented")
    `SGIIR_ASSERT_NXT(a_unchecked_no_swap, clk, rst_n, cmd.take && mode, !rep_reg, "unchecked sample marked as replaced")

endmodule

`default_nettype wire

// ===== dv/tb_spike_gated_iir_filter.sv =====
`timescale 1ns / 1ps

module tb_spike_gated_iir_filter;
    import sgiir_pkg::*;

    localparam int NUM_TAPS    = 4;
    localparam int CLK_HALF    = 6;
    localparam int QUIET_LIMIT = 3000;  // cycles without any handshake
    localparam int SETTLE      = 2 * NUM_TAPS + 4;
    localparam int LONG_STALL  = 250;

    // Input mode encoding.
    localparam logic MODE_CHECKED = 1'b0;
    localparam logic MODE_RAW     = 1'b1;

    localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;
    localparam longint HALF_LSB = longint'(1) <<< (ROUND_SHIFT - 1);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       mode;
    } sample_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       replaced;
        logic                       clipped;
    } filter_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sgiir_in_if  sample_ch ();
    sgiir_out_if result_ch ();

    // Filter state and register copies kept alongside the block.
    logic signed [COEF_W-1:0]   feed_q  [0:NUM_FEED_REGS-1];
    logic signed [COEF_W-1:0]   fbk_q   [1:NUM_FBK_REGS];
    logic signed [SAMPLE_W-1:0] limit_q;
    logic signed [ACC_W-1:0]    delay_q [0:NUM_FEED_REGS-2];
    logic signed [SAMPLE_W-1:0] prev_raw_q;

    sample_req_t sample_backlog[$];   // requests not yet offered
    filter_out_t outputs_in_flight[$]; // outputs owed by accepted requests

    int send_idle_pct;
    int recv_idle_pct;
    int err_count;
    int quiet_cycles;
    int results_taken;
    int stall_left;

    spike_gated_iir_filter #(
        .TAPS (NUM_TAPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Clamp a wide sum to the 48-bit accumulator range.
    function automatic longint clamp_acc(input longint v);
        if (v > ACC_MAX)
        begin
            return ACC_MAX;
        end
        if (v < ACC_MIN)
        begin
            return ACC_MIN;
        end
        return v;
    endfunction

    // Advance the filter by one sample and return the output it produces.
    function automatic filter_out_t filter_sample(input logic signed [SAMPLE_W-1:0] raw,
                                                  input logic mode);
        filter_out_t                res;
        logic signed [SAMPLE_W-1:0] x;
        longint                     acc;
        longint                     y;
        longint                     nxt;
        res.replaced = 1'b0;
        res.clipped  = 1'b0;
        x = raw;
        // Checked samples gate spikes; every checked raw sample becomes the
        // new previous sample, spikes included.
        if (mode == MODE_CHECKED)
        begin
            if (raw > limit_q)
            begin
                x = prev_raw_q;
                res.replaced = 1'b1;
            end
            prev_raw_q = raw;
        end
        acc = clamp_acc(longint'(delay_q[0]) + longint'(feed_q[0]) * longint'(x));
        // Round half up, then saturate to Q15.8.
        y = (acc + HALF_LSB) >>> ROUND_SHIFT;
        if (y > OUT_MAX)
        begin
            y = OUT_MAX;
            res.clipped = 1'b1;
        end
        else if (y < OUT_MIN)
        begin
            y = OUT_MIN;
            res.clipped = 1'b1;
        end
        // Shift the transposed delay line; the last term takes no older input.
        for (int k = 0; k < NUM_FEED_REGS - 1; k++)
        begin
            nxt = (k < NUM_FEED_REGS - 2) ? longint'(delay_q[k+1]) : 0;
            delay_q[k] = ACC_W'(clamp_acc(nxt + longint'(feed_q[k+1]) * longint'(x)
                                          - longint'(fbk_q[k+1]) * y));
        end
        res.filtered = SAMPLE_W'(y);
        return res;
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef(input int unsigned span);
        return COEF_W'(int'($urandom_range(2 * span)) - int'(span));
    endfunction

    // Bias samples toward the spike threshold and the format extremes.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0, 1:    return limit_q + SAMPLE_W'($urandom_range(4)) - SAMPLE_W'(2);
            2:       return ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            3, 4:    return SAMPLE_W'(int'($urandom_range(4096)) - 2048);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Write one register and mirror it into the local copy.
    task automatic set_reg(input int idx, input logic signed [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= val;
        if (idx < REG_FEEDBACK_1)
        begin
            feed_q[idx - REG_FEED_0] = val;
        end
        else if (idx < REG_SPIKE_LIMIT)
        begin
            fbk_q[idx - REG_FEEDBACK_1 + 1] = val;
        end
        else
        begin
            limit_q = val;
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Load random coefficients within the given spans and a fresh spike limit.
    task automatic configure(input int unsigned feed_span, input int unsigned fbk_span);
        for (int k = 0; k < NUM_FEED_REGS; k++)
        begin
            set_reg(REG_FEED_0 + k, rand_coef(feed_span));
        end
        for (int k = 0; k < NUM_FBK_REGS; k++)
        begin
            set_reg(REG_FEEDBACK_1 + k, rand_coef(fbk_span));
        end
        if ($urandom_range(1) != 0)
        begin
            set_reg(REG_SPIKE_LIMIT, rand_coef(100000));
        end
        else
        begin
            set_reg(REG_SPIKE_LIMIT, CFG_DATA_W'($urandom()));
        end
    endtask

    // Drive every register to one value (used for the range extremes).
    task automatic configure_uniform(input logic signed [CFG_DATA_W-1:0] val);
        for (int idx = REG_FEED_0; idx <= REG_SPIKE_LIMIT; idx++)
        begin
            set_reg(idx, val);
        end
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input logic m);
        sample_req_t r;
        r.sample = s;
        r.mode   = m;
        sample_backlog.push_back(r);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            queue_sample(pick_sample(), ($urandom_range(3) == 0) ? MODE_RAW : MODE_CHECKED);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Wait until every request is out and answered, then let the pipe settle.
    task automatic drain();
        @(negedge clk);
        while (sample_backlog.size() != 0 || sample_ch.valid || outputs_in_flight.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // Request driver: pop the next sample once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_req_t nxt;
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= '0;
            sample_ch.mode   <= MODE_CHECKED;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = sample_backlog.pop_front();
                sample_ch.valid  <= 1'b1;
                sample_ch.sample <= nxt.sample;
                sample_ch.mode   <= nxt.mode;
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: random back-pressure plus two long hold-offs that let the
    // block fill up and stall its input while requests keep coming.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            results_taken = 0;
            stall_left    = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_taken++;
                if (results_taken == 400 || results_taken == 800)
                begin
                    stall_left = LONG_STALL;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Monitor: check taken outputs first, then predict for a newly taken request,
    // so a stray output can never match an expectation from the same edge.
    always @(posedge clk)
    begin : output_monitor
        filter_out_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (outputs_in_flight.size() == 0)
                begin
                    $display("%0t: unexpected output filtered=%0d replaced=%0b clipped=%0b",
                             $time, result_ch.filtered, result_ch.replaced, result_ch.clipped);
                    err_count++;
                end
                else
                begin
                    want = outputs_in_flight.pop_front();
                    if (result_ch.filtered !== want.filtered)
                    begin
                        $display("%0t: filtered expected %0d actual %0d",
                                 $time, want.filtered, result_ch.filtered);
                        err_count++;
                    end
                    if (result_ch.replaced !== want.replaced)
                    begin
                        $display("%0t: replaced expected %0b actual %0b",
                                 $time, want.replaced, result_ch.replaced);
                        err_count++;
                    end
                    if (result_ch.clipped !== want.clipped)
                    begin
                        $display("%0t: clipped expected %0b actual %0b",
                                 $time, want.clipped, result_ch.clipped);
                        err_count++;
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                outputs_in_flight.push_back(filter_sample(sample_ch.sample, sample_ch.mode));
            end
        end
    end

    // Watchdog: give up when no handshake happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_spike_gated_iir_filter failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        sample_ch.mode   = MODE_CHECKED;
        result_ch.ready  = 1'b0;
        send_idle_pct    = 9;
        recv_idle_pct    = 71;
        err_count        = 0;
        quiet_cycles     = 0;

        // Mirror the reset state: unity b0, everything else zero, limit 500.0.
        for (int k = 0; k < NUM_FEED_REGS; k++)
        begin
            feed_q[k] = '0;
        end
        for (int k = 1; k <= NUM_FBK_REGS; k++)
        begin
            fbk_q[k] = '0;
        end
        for (int k = 0; k < NUM_FEED_REGS - 1; k++)
        begin
            delay_q[k] = '0;
        end
        feed_q[0]  = FEED0_RESET;
        limit_q    = SPIKE_RESET;
        prev_raw_q = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset settings: extremes, threshold edges, both modes.
        queue_sample(24'sd0, MODE_CHECKED);
        queue_sample(24'sd1, MODE_CHECKED);
        queue_sample(-24'sd1, MODE_CHECKED);
        queue_sample(SAMPLE_MAX, MODE_RAW);         // unchecked, passes as is
        queue_sample(SAMPLE_MAX, MODE_CHECKED);     // spike, replaced by -1
        queue_sample(SAMPLE_MIN, MODE_CHECKED);     // far below, kept
        queue_sample(SPIKE_RESET, MODE_CHECKED);    // at the limit, not a spike
        queue_sample(SPIKE_RESET + 24'sd1, MODE_CHECKED);
        queue_sample(SPIKE_RESET + 24'sd1, MODE_RAW);    // previous sample untouched
        queue_sample(24'sd200000, MODE_CHECKED);    // back-to-back spikes
        queue_sample(24'sd300000, MODE_CHECKED);
        queue_sample(SAMPLE_MIN, MODE_RAW);
        queue_sample(24'sd256, MODE_CHECKED);
        queue_sample(24'sd127, MODE_CHECKED);       // below 0.5; unity b0 passes it unrounded
        queue_sample(-24'sd128, MODE_CHECKED);
        drain();

        // Directed, gain near 8: saturate the output both ways.
        set_reg(REG_FEED_0, SAMPLE_MAX);
        queue_sample(SAMPLE_MAX, MODE_RAW);
        queue_sample(SAMPLE_MIN, MODE_RAW);
        queue_sample(24'sd256, MODE_CHECKED);
        queue_sample(SAMPLE_MIN, MODE_CHECKED);
        queue_sample(24'sd1048576, MODE_CHECKED);
        queue_sample(-24'sd1048576, MODE_RAW);
        drain();

        // Sender mostly busy, receiver mostly stalling.
        configure(1 << 18, 1 << 18);
        queue_random(200);
        drain();
        configure_uniform(SAMPLE_MAX);
        queue_random(60);
        drain();

        // Swap the idling around.
        set_idling(71, 9);
        configure_uniform(SAMPLE_MIN);
        queue_random(60);
        drain();
        configure(1 << 23, 1 << 23);
        queue_random(150);
        drain();
        configure(1 << 18, 1 << 18);
        queue_random(130);
        drain();

        // Full rate on both sides.
        set_idling(0, 0);
        configure(1 << 20, 1 << 16);
        queue_random(150);
        drain();
        configure(1 << 18, 1 << 19);
        queue_random(150);
        drain();

        if (err_count == 0)
        begin
            $display("tb_spike_gated_iir_filter passed");
        end
        else
        begin
            $display("tb_spike_gated_iir_filter failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sgiir_pkg.sv
rtl/sgiir_if.sv
rtl/sgiir_ctrl.sv
rtl/sgiir_datapath.sv
rtl/spike_gated_iir_filter.sv
dv/tb_spike_gated_iir_filter.sv
